/* hw/rtl/vfrb_pkg.sv */
// ----------------------------------------------------------------------------
// vfrb_pkg
// shared widths, defaults and codes of the video frame reorder buffer
// ----------------------------------------------------------------------------
package vfrb_pkg;

  localparam int unsigned DefDepth      = 32;
  localparam int unsigned DefHandleBits = 16;

  localparam int unsigned OpW      = 2;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CntOutW  = 6;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpGet    = 2'd1;
  localparam logic [OpW-1:0] OpFlush  = 2'd2;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StDup     = 3'd1;
  localparam logic [StatusW-1:0] StFull    = 3'd2;
  localparam logic [StatusW-1:0] StEmpty   = 3'd3;
  localparam logic [StatusW-1:0] StNotDec  = 3'd4;
  localparam logic [StatusW-1:0] StFlushed = 3'd5;

endpackage

/* hw/rtl/vfrb_ram.sv */
// ----------------------------------------------------------------------------
// vfrb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module vfrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/video_frame_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// video_frame_reorder_buffer
// frames kept in ascending sequence order in a ring held in one ram
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall_o is high from acceptance until
// the result is handed to the output register, which can hold one finished
// word while the next command is accepted. Frames live in a ring in a single
// ram with one read and one write port, so the memory walk sets the time: a
// get reads the head entry and then hands over, a flush or an unused opcode
// goes straight to the hand-over, and an insert runs the ascending search
// for the insertion point, one entry per cycle, then moves the frames at and
// above that point up by one slot, unless the frame goes to the tail, and
// then places the frame; a duplicate or full insert ends after the search. A
// finished word waits for the output register to empty before hand-over.
// Dropping frames ahead of a key frame and popping only move the ring head
// and count; flushing only clears the count.
// ----------------------------------------------------------------------------
module video_frame_reorder_buffer #(
  parameter int unsigned DEPTH       = vfrb_pkg::DefDepth,
  parameter int unsigned HANDLE_BITS = vfrb_pkg::DefHandleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vfrb_pkg::OpW-1:0]     opcode_i,
  input  logic [vfrb_pkg::SeqW-1:0]    seq_number_i,
  input  logic                         is_key_i,
  input  logic [HANDLE_BITS-1:0]       frame_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vfrb_pkg::StatusW-1:0] status_o,
  output logic [vfrb_pkg::SeqW-1:0]    out_seq_o,
  output logic                         out_is_key_o,
  output logic [HANDLE_BITS-1:0]       out_handle_o,
  output logic [vfrb_pkg::CntOutW-1:0] dropped_count_o,
  output logic [vfrb_pkg::CntOutW-1:0] occupancy_o
);

  import vfrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = SeqW + 1 + HANDLE_BITS;
  localparam logic [AW:0] DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_GET,
    S_OUT
  } state_e;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthA) begin
      sum = sum - DepthA;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [CntOutW-1:0] sat6(input logic [CW-1:0] v);
    logic [CW+CntOutW-1:0] w;
    w = {{CntOutW{1'b0}}, v};
    if (w > (CW + CntOutW)'({CntOutW{1'b1}})) begin
      return {CntOutW{1'b1}};
    end
    return w[CntOutW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [OpW-1:0]       op_q, op_d;
  logic [SeqW-1:0]      seq_q, seq_d;
  logic                 key_q, key_d;
  logic [HANDLE_BITS-1:0] hdl_q, hdl_d;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [SeqW-1:0]      last_q, last_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [CW-1:0]        wr_off_q, wr_off_d;
  logic                 pend_q, pend_d;
  logic                 rd_act_q, rd_act_d;

  logic [StatusW-1:0]     res_status_q, res_status_d;
  logic [SeqW-1:0]        res_seq_q, res_seq_d;
  logic                   res_key_q, res_key_d;
  logic [HANDLE_BITS-1:0] res_hdl_q, res_hdl_d;
  logic [CntOutW-1:0]     res_drop_q, res_drop_d;
  logic [CntOutW-1:0]     res_occ_q, res_occ_d;

  logic                   out_valid_q, out_valid_d;
  logic [StatusW-1:0]     out_status_q, out_status_d;
  logic [SeqW-1:0]        out_seq_q, out_seq_d;
  logic                   out_key_q, out_key_d;
  logic [HANDLE_BITS-1:0] out_hdl_q, out_hdl_d;
  logic [CntOutW-1:0]     out_drop_q, out_drop_d;
  logic [CntOutW-1:0]     out_occ_q, out_occ_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [AW-1:0]          rd_off;
  logic [SeqW-1:0]        rd_seq;
  logic                   rd_key;
  logic [HANDLE_BITS-1:0] rd_hdl;

  logic                   stop;
  logic                   dup;
  logic [CW-1:0]          found_pos;
  logic [CW-1:0]          cur;
  logic [CW-1:0]          new_count;

  assign {rd_seq, rd_key, rd_hdl} = ram_rdata;

  always_comb begin
    case (state_q)
      S_SCAN, S_SHIFT: rd_off = idx_q[AW-1:0];
      default:         rd_off = '0;
    endcase
  end

  assign ram_raddr = phys(head_q, rd_off);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head_q, pos_q[AW-1:0]);
    ram_wdata = {seq_q, key_q, hdl_q};
    if (state_q == S_SHIFT && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = phys(head_q, wr_off_q[AW-1:0]);
      ram_wdata = ram_rdata;
    end else if (state_q == S_PLACE) begin
      ram_we = 1'b1;
    end
  end

  vfrb_ram #(
    .Width (EW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search for the first stored frame not below the new number
  always_comb begin
    cur       = idx_q - OneC;
    stop      = 1'b0;
    dup       = 1'b0;
    found_pos = '0;
    if (!pend_q) begin
      stop = 1'b1;
    end else if (rd_seq >= seq_q) begin
      stop      = 1'b1;
      dup       = (rd_seq == seq_q);
      found_pos = cur;
    end else if (cur == count_q - OneC) begin
      stop      = 1'b1;
      found_pos = count_q;
    end
  end

  assign new_count = count_q + OneC;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    seq_d        = seq_q;
    key_d        = key_q;
    hdl_d        = hdl_q;
    head_d       = head_q;
    count_d      = count_q;
    last_d       = last_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    wr_off_d     = wr_off_q;
    pend_d       = pend_q;
    rd_act_d     = rd_act_q;
    res_status_d = res_status_q;
    res_seq_d    = res_seq_q;
    res_key_d    = res_key_q;
    res_hdl_d    = res_hdl_q;
    res_drop_d   = res_drop_q;
    res_occ_d    = res_occ_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_seq_d    = out_seq_q;
    out_key_d    = out_key_q;
    out_hdl_d    = out_hdl_q;
    out_drop_d   = out_drop_q;
    out_occ_d    = out_occ_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = opcode_i;
          seq_d        = seq_number_i;
          key_d        = is_key_i;
          hdl_d        = frame_handle_i;
          res_status_d = StOk;
          res_seq_d    = '0;
          res_key_d    = 1'b0;
          res_hdl_d    = '0;
          res_drop_d   = '0;
          res_occ_d    = sat6(count_q);
          case (opcode_i)
            OpInsert: begin
              idx_d   = OneC;
              pend_d  = (count_q != '0);
              state_d = S_SCAN;
            end
            OpGet: begin
              if (count_q == '0) begin
                res_status_d = StEmpty;
                state_d      = S_OUT;
              end else begin
                state_d = S_GET;
              end
            end
            OpFlush: begin
              res_status_d = StFlushed;
              res_drop_d   = sat6(count_q);
              res_occ_d    = '0;
              count_d      = '0;
              state_d      = S_OUT;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q < count_q) begin
          idx_d  = idx_q + OneC;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (stop) begin
          pos_d = found_pos;
          if (dup) begin
            res_status_d = StDup;
            state_d      = S_OUT;
          end else if (count_q == DepthC) begin
            res_status_d = StFull;
            state_d      = S_OUT;
          end else if (found_pos == count_q) begin
            state_d = S_PLACE;
          end else begin
            idx_d    = count_q - OneC;
            pend_d   = 1'b0;
            rd_act_d = 1'b1;
            state_d  = S_SHIFT;
          end
        end
      end

      // move frames at and above the insertion point up by one slot
      S_SHIFT: begin
        pend_d   = rd_act_q;
        wr_off_d = idx_q + OneC;
        rd_act_d = rd_act_q && (idx_q != pos_q);
        if (rd_act_q && idx_q != pos_q) begin
          idx_d = idx_q - OneC;
        end
        if (!rd_act_q && pend_q) begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        if (key_q) begin
          head_d     = phys(head_q, pos_q[AW-1:0]);
          count_d    = new_count - pos_q;
          res_drop_d = sat6(pos_q);
          res_occ_d  = sat6(new_count - pos_q);
        end else begin
          count_d   = new_count;
          res_occ_d = sat6(new_count);
        end
        state_d = S_OUT;
      end

      S_GET: begin
        if (rd_key || rd_seq == last_q + SeqW'(1)) begin
          last_d    = rd_seq;
          res_seq_d = rd_seq;
          res_key_d = rd_key;
          res_hdl_d = rd_hdl;
          head_d    = phys(head_q, AW'(1));
          count_d   = count_q - OneC;
          res_occ_d = sat6(count_q - OneC);
        end else begin
          res_status_d = StNotDec;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_seq_d    = res_seq_q;
          out_key_d    = res_key_q;
          out_hdl_d    = res_hdl_q;
          out_drop_d   = res_drop_q;
          out_occ_d    = res_occ_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      seq_q        <= '0;
      key_q        <= 1'b0;
      hdl_q        <= '0;
      head_q       <= '0;
      count_q      <= '0;
      last_q       <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      wr_off_q     <= '0;
      pend_q       <= 1'b0;
      rd_act_q     <= 1'b0;
      res_status_q <= '0;
      res_seq_q    <= '0;
      res_key_q    <= 1'b0;
      res_hdl_q    <= '0;
      res_drop_q   <= '0;
      res_occ_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_seq_q    <= '0;
      out_key_q    <= 1'b0;
      out_hdl_q    <= '0;
      out_drop_q   <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      seq_q        <= seq_d;
      key_q        <= key_d;
      hdl_q        <= hdl_d;
      head_q       <= head_d;
      count_q      <= count_d;
      last_q       <= last_d;
      idx_q        <= idx_d;
      pos_q        <= pos_d;
      wr_off_q     <= wr_off_d;
      pend_q       <= pend_d;
      rd_act_q     <= rd_act_d;
      res_status_q <= res_status_d;
      res_seq_q    <= res_seq_d;
      res_key_q    <= res_key_d;
      res_hdl_q    <= res_hdl_d;
      res_drop_q   <= res_drop_d;
      res_occ_q    <= res_occ_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_seq_q    <= out_seq_d;
      out_key_q    <= out_key_d;
      out_hdl_q    <= out_hdl_d;
      out_drop_q   <= out_drop_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_seq_o       = out_seq_q;
  assign out_is_key_o    = out_key_q;
  assign out_handle_o    = out_hdl_q;
  assign dropped_count_o = out_drop_q;
  assign occupancy_o     = out_occ_q;

  // the ring never holds more frames than it has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("frame count beyond depth");

  // a new result word only appears after the hand-over state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result word without hand-over");

  // shifting only happens below the tail of a list that is not full
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (pos_q < count_q && count_q < DepthC))
    else $error("shift outside stored range");

  // ram writes only come from the shift and place steps of an insert
  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_SHIFT || state_q == S_PLACE) && op_q == OpInsert))
    else $error("ram write outside insert");

  // placing a frame always leaves at least that frame stored
  a_place_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |=> (count_q != '0))
    else $error("insert left the list empty");

endmodule
